// File: hw/rtl/lcce_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Lighting channel command encoder package
// Command codes, register indexes, packet byte constants, the handover record
// between the command stage and the serializer, and the brightness mapping.
// ----------------------------------------------------------------------------
package lcce_pkg;

	typedef enum logic [1:0] {
		CMD_SET    = 2'd0,
		CMD_FRAME  = 2'd1,
		CMD_FORGET = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_e;

	localparam logic [1:0] REG_ENABLE      = 2'd0;
	localparam logic [1:0] REG_RESEND      = 2'd1;
	localparam logic [1:0] REG_HB_INTERVAL = 2'd2;

	localparam logic       ENABLE_RST      = 1'b1;
	localparam logic [7:0] RESEND_RST      = 8'd200;
	localparam logic [15:0] HB_INTERVAL_RST = 16'd300;

	localparam logic [7:0] LEVEL_RST  = 8'hFF;
	localparam logic [7:0] COUNT_RST  = 8'hF0;
	localparam logic [7:0] COUNT_MAX  = 8'hFF;
	localparam logic [7:0] UNIT_LIMIT = 8'hF0;

	localparam logic [7:0] BYTE_ZERO   = 8'h00;
	localparam logic [7:0] OP_SET      = 8'h03;
	localparam logic [7:0] CHAN_MARK   = 8'h80;
	localparam logic [7:0] HB_UNIT     = 8'hFF;
	localparam logic [7:0] HB_OP       = 8'h81;
	localparam logic [7:0] HB_ARG      = 8'h56;
	localparam logic [2:0] SET_LAST    = 3'd5;
	localparam logic [2:0] HB_LAST     = 3'd4;

	typedef enum logic [0:0] {
		PKT_SET   = 1'b0,
		PKT_HBEAT = 1'b1
	} pkt_kind_e;

	typedef struct packed {
		pkt_kind_e  kind;
		logic [7:0] unit;
		logic [7:0] bright;
		logic [3:0] nib;
	} pkt_req_t;

	// 240 - ceil(239 * level / 255); the division by 255 uses the
	// (x + (x >> 8) + 1) >> 8 identity, exact for x below 65535.
	function automatic logic [7:0] brightness_code(input logic [7:0] level);
		logic [15:0] p;
		logic [16:0] x;
		logic [16:0] d;
		p = 16'd239 * {8'd0, level};
		x = 17'(p) + 17'd254;
		d = (x + (x >> 8) + 17'd1) >> 8;
		return 8'(9'd240 - 9'(d));
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/lcce_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module lcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/lcce_serializer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Packet serializer
// Holds one packet request and emits its bytes, one transfer per cycle while pkt_stall is low.
// ----------------------------------------------------------------------------
module lcce_serializer (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               req_valid,
	input  wire lcce_pkg::pkt_req_t req,
	output logic              req_ready,
	output logic              pkt_valid,
	input  wire               pkt_stall,
	output logic [7:0]        out_byte,
	output logic              last_byte
);

	import lcce_pkg::*;

	logic       busy_q;
	logic [2:0] idx_q;
	pkt_req_t   req_q;
	logic       xfer;

	assign pkt_valid = busy_q;
	assign xfer      = busy_q && !pkt_stall;
	assign last_byte = (req_q.kind == PKT_SET) ? (idx_q == SET_LAST) : (idx_q == HB_LAST);
	assign req_ready = !busy_q || (xfer && last_byte);

	always_comb begin
		out_byte = BYTE_ZERO;
		if (req_q.kind == PKT_SET) begin
			case (idx_q)
				3'd1: out_byte = req_q.unit;
				3'd2: out_byte = OP_SET;
				3'd3: out_byte = req_q.bright;
				3'd4: out_byte = CHAN_MARK | {4'd0, req_q.nib};
				default: out_byte = BYTE_ZERO;
			endcase
		end else begin
			case (idx_q)
				3'd1: out_byte = HB_UNIT;
				3'd2: out_byte = HB_OP;
				3'd3: out_byte = HB_ARG;
				default: out_byte = BYTE_ZERO;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 3'd0;
		end else if (req_valid && req_ready) begin
			busy_q <= 1'b1;
			idx_q  <= 3'd0;
		end else if (xfer) begin
			if (last_byte) begin
				busy_q <= 1'b0;
			end
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/lighting_channel_command_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Lighting channel command encoder core
// Turns set-level, frame-end and heartbeat-reset commands into serial packet
// bytes, keeping the last sent level and an unsent count per channel in RAM.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  cmd      cmd_valid / cmd_stall  command, channel, level, time_ms
//  pkt      pkt_valid / pkt_stall  out_byte, last_byte
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A command is read from the channel RAM at its transfer and decided in the
// following cycle; a back-to-back update of the same channel is forwarded.
// A set packet has six bytes and a heartbeat five, so the serializer sets the
// sustained rate; commands that send nothing pass at one per cycle unless stalled.
// After reset a clearing pass fills every RAM entry with stall held.
// A stalled output holds the serializer, which in turn stalls the command stage.
module lighting_channel_command_encoder_core #(
	parameter int CHANNELS = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cmd_valid,
	output logic        cmd_stall,
	input  wire  [1:0]  command,
	input  wire  [11:0] channel,
	input  wire  [7:0]  level,
	input  wire  [31:0] time_ms,
	output logic        pkt_valid,
	input  wire         pkt_stall,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data
);

	import lcce_pkg::*;

	localparam int AW = $clog2(CHANNELS);

	logic          enable_q;
	logic [7:0]    resend_q;
	logic [15:0]   hb_interval_q;
	logic          hb_seen_q;
	logic [31:0]   hb_time_q;

	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	logic          valid_s1;
	cmd_e          cmd_s1;
	logic [11:0]   chan_s1;
	logic [7:0]    level_s1;
	logic [7:0]    bright_s1;
	logic [31:0]   time_s1;
	logic          in_range_s1;
	logic          fwd_valid_s1;
	logic [15:0]   fwd_data_s1;

	logic          acc;
	logic [15:0]   rdata;
	logic [15:0]   cur;
	logic [7:0]    cur_level;
	logic [7:0]    cur_count;
	logic          is_set;
	logic          set_send;
	logic          hb_fire;
	logic [32:0]   hb_limit;
	logic          need_pkt;
	logic          ser_ready;
	logic          done;
	logic          upd_we;
	logic [15:0]   upd_data;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	pkt_req_t      req;
	logic [7:0]    unit_raw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q      <= ENABLE_RST;
			resend_q      <= RESEND_RST;
			hb_interval_q <= HB_INTERVAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE:      enable_q      <= cfg_data[0];
				REG_RESEND:      resend_q      <= cfg_data[7:0];
				REG_HB_INTERVAL: hb_interval_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == AW'(CHANNELS - 1)) begin
				clr_busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	assign cur       = fwd_valid_s1 ? fwd_data_s1 : rdata;
	assign cur_level = cur[15:8];
	assign cur_count = cur[7:0];

	assign is_set   = enable_q && (cmd_s1 == CMD_SET) && in_range_s1;
	assign set_send = (cur_level != level_s1) || (cur_count > resend_q);
	assign hb_limit = {1'b0, hb_time_q} + 33'(hb_interval_q);
	assign hb_fire  = enable_q && (cmd_s1 == CMD_FRAME) &&
		(!hb_seen_q || (time_s1 < hb_time_q) || ({1'b0, time_s1} > hb_limit));
	assign need_pkt = (is_set && set_send) || hb_fire;
	assign done     = valid_s1 && (!need_pkt || ser_ready);

	assign cmd_stall = clr_busy_q || (valid_s1 && !done);
	assign acc       = cmd_valid && !cmd_stall;

	assign upd_we   = done && is_set;
	assign upd_data = set_send ? {level_s1, 8'd0} :
		{cur_level, (cur_count == COUNT_MAX) ? cur_count : cur_count + 8'd1};

	assign ram_we    = clr_busy_q || upd_we;
	assign ram_waddr = clr_busy_q ? clr_addr_q : chan_s1[AW-1:0];
	assign ram_wdata = clr_busy_q ? {LEVEL_RST, COUNT_RST} : upd_data;

	lcce_ram #(
		.WIDTH(16),
		.DEPTH(CHANNELS)
	) u_chan_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (acc),
		.raddr (channel[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			fwd_valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1     <= 1'b1;
			fwd_valid_s1 <= upd_we && (chan_s1[AW-1:0] == channel[AW-1:0]);
		end else if (done) begin
			valid_s1     <= 1'b0;
			fwd_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1      <= cmd_e'(command);
			chan_s1     <= channel;
			level_s1    <= level;
			bright_s1   <= brightness_code(level);
			time_s1     <= time_ms;
			in_range_s1 <= ({1'b0, channel} < 13'(CHANNELS));
			fwd_data_s1 <= upd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hb_seen_q <= 1'b0;
			hb_time_q <= 32'd0;
		end else if (done && enable_q) begin
			if (hb_fire) begin
				hb_seen_q <= 1'b1;
				hb_time_q <= time_s1;
			end else if (cmd_s1 == CMD_FORGET) begin
				hb_seen_q <= 1'b0;
			end
		end
	end

	assign unit_raw   = chan_s1[11:4];
	assign req.kind   = hb_fire ? PKT_HBEAT : PKT_SET;
	assign req.unit   = (unit_raw < UNIT_LIMIT) ? unit_raw + 8'd1 : unit_raw;
	assign req.bright = bright_s1;
	assign req.nib    = chan_s1[3:0];

	lcce_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (valid_s1 && need_pkt),
		.req       (req),
		.req_ready (ser_ready),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule
`default_nettype wire
